FILE: rtl/atrf_pkg.sv
// atrf_pkg: shared types, codes and character constants of the AT response framer
// depends on nothing; used by atrf_in_stage, atrf_core, the top and the bench
`timescale 1ns / 1ps

package atrf_pkg;

    localparam int BODY_LIMIT_DEF = 2048;
    localparam int RX_BYTE_W      = 8;
    localparam int BODY_INDEX_W   = 11;

    typedef logic [RX_BYTE_W-1:0] t_byte;

    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_HEAD     = 3'd1,
        EV_OK       = 3'd2,
        EV_ERR      = 3'd3,
        EV_UNKNOWN  = 3'd4,
        EV_BODY     = 3'd5,
        EV_DONE     = 3'd6,
        EV_OVERFLOW = 3'd7
    } t_event;

    localparam t_byte SYNC_CHAR = 8'h2B;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_LF     = 8'h0A;

    // input item as held in the input register
    typedef struct packed {
        logic  valid;
        t_byte rx_byte;
    } t_item;

    typedef struct packed {
        t_event                  event_res;
        t_byte                   body_byte;
        logic [BODY_INDEX_W-1:0] body_index;
        logic                    response_ok;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // "OK" by header position
    function automatic t_byte ok_char(input logic pos);
        t_byte c;
        c = pos ? 8'h4B : 8'h4F;
        return c;
    endfunction

    // "ERR" by header position
    function automatic t_byte err_char(input logic [1:0] pos);
        t_byte c;
        case (pos)
            2'd0:    c = 8'h45;
            2'd1:    c = 8'h52;
            2'd2:    c = 8'h52;
            default: c = 8'h45;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/atrf_stream_if.sv
// atrf_stream_if: valid/ready stream channel with a flat payload vector
// no dependencies
`timescale 1ns / 1ps

interface atrf_stream_if #(
    parameter int W = 8
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/atrf_in_stage.sv
// atrf_in_stage: input register of the framer, one byte deep
// depends on atrf_pkg
`timescale 1ns / 1ps

module atrf_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  atrf_pkg::t_byte       i_rx_byte,
    input  logic                  i_take,
    output logic                  o_ready,
    output atrf_pkg::t_item       o_item
);
    import atrf_pkg::*;

    logic  r_valid;
    t_byte r_rx_byte;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rx_byte <= i_rx_byte;
        end
    end

    assign o_item = '{valid: r_valid, rx_byte: r_rx_byte};

endmodule

FILE: rtl/atrf_core.sv
// atrf_core: framer state, per-byte event logic and the result register
// depends on atrf_pkg
`timescale 1ns / 1ps

module atrf_core #(
    parameter int BODY_LIMIT = atrf_pkg::BODY_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atrf_pkg::t_item   i_item,
    input  logic              i_ready,
    output logic              o_take,
    output logic              o_valid,
    output atrf_pkg::t_result o_result
);
    import atrf_pkg::*;

    localparam int CW = $clog2(BODY_LIMIT);
    localparam logic [CW-1:0] LAST_IDX = CW'(BODY_LIMIT - 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [1:0]    r_hdr_cnt, n_hdr_cnt;
    logic          r_ok_alive, n_ok_alive;
    logic          r_err_alive, n_err_alive;
    logic [1:0]    r_term, n_term;
    logic [CW-1:0] r_body_cnt, n_body_cnt;
    logic          r_ok_flag, n_ok_flag;
    logic          r_out_valid;
    t_result       r_out, n_out;

    t_byte                      w_b;
    logic                       w_ok_m;
    logic                       w_err_m;
    logic [1:0]                 w_p;
    logic                       w_done;
    logic [CW+BODY_INDEX_W-1:0] w_idx_ext;
    logic                       w_fire;

    assign o_take    = !r_out_valid || i_ready;
    assign w_fire    = i_item.valid && o_take;
    assign w_b       = i_item.rx_byte;
    assign w_idx_ext = {{BODY_INDEX_W{1'b0}}, r_body_cnt};

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_ok_alive  = r_ok_alive;
        n_err_alive = r_err_alive;
        n_term      = r_term;
        n_body_cnt  = r_body_cnt;
        n_ok_flag   = r_ok_flag;
        n_out       = '{event_res: EV_IGNORED, body_byte: '0, body_index: '0,
                        response_ok: 1'b0};
        w_ok_m      = r_ok_alive && (r_hdr_cnt < 2'd2) && (w_b == ok_char(r_hdr_cnt[0]));
        w_err_m     = r_err_alive && (r_hdr_cnt < 2'd3) && (w_b == err_char(r_hdr_cnt));
        w_p         = r_term;
        w_done      = 1'b0;

        case (r_phase)
            PH_HEAD: begin
                if (w_ok_m && r_hdr_cnt == 2'd1) begin
                    n_out.event_res = EV_OK;
                    n_ok_flag       = 1'b1;
                    n_phase         = PH_BODY;
                    n_hdr_cnt       = '0;
                    n_ok_alive      = 1'b1;
                    n_err_alive     = 1'b1;
                    n_term          = '0;
                    n_body_cnt      = '0;
                end else if (w_err_m && r_hdr_cnt == 2'd2) begin
                    n_out.event_res = EV_ERR;
                    n_ok_flag       = 1'b0;
                    n_phase         = PH_BODY;
                    n_hdr_cnt       = '0;
                    n_ok_alive      = 1'b1;
                    n_err_alive     = 1'b1;
                    n_term          = '0;
                    n_body_cnt      = '0;
                end else if (!w_ok_m && !w_err_m) begin
                    n_out.event_res = EV_UNKNOWN;
                    n_ok_flag       = 1'b0;
                    n_phase         = PH_IDLE;
                    n_hdr_cnt       = '0;
                    n_ok_alive      = 1'b1;
                    n_err_alive     = 1'b1;
                    n_term          = '0;
                    n_body_cnt      = '0;
                end else begin
                    n_out.event_res = EV_HEAD;
                    n_ok_alive      = w_ok_m;
                    n_err_alive     = w_err_m;
                    n_hdr_cnt       = r_hdr_cnt + 2'd1;
                end
            end
            PH_BODY: begin
                // running match of cr lf cr lf
                if (w_b == (r_term[0] ? CH_LF : CH_CR)) begin
                    if (r_term == 2'd3) begin
                        w_done = 1'b1;
                    end else begin
                        w_p = r_term + 2'd1;
                    end
                end else begin
                    w_p = (w_b == CH_CR) ? 2'd1 : 2'd0;
                end
                if (w_done) begin
                    n_out.event_res  = EV_DONE;
                    n_out.body_byte  = w_b;
                    n_out.body_index = w_idx_ext[BODY_INDEX_W-1:0];
                    n_phase          = PH_IDLE;
                    n_term           = '0;
                    n_body_cnt       = '0;
                end else if (r_body_cnt == LAST_IDX) begin
                    n_out.event_res = EV_OVERFLOW;
                    n_phase         = PH_IDLE;
                    n_term          = '0;
                    n_body_cnt      = '0;
                end else begin
                    n_out.event_res  = EV_BODY;
                    n_out.body_byte  = w_b;
                    n_out.body_index = w_idx_ext[BODY_INDEX_W-1:0];
                    n_term           = w_p;
                    n_body_cnt       = r_body_cnt + CW'(1);
                end
            end
            default: begin
                // idle and the unused phase code
                n_out.event_res = (w_b == SYNC_CHAR) ? EV_HEAD : EV_IGNORED;
                n_phase         = (w_b == SYNC_CHAR) ? PH_HEAD : PH_IDLE;
                n_hdr_cnt       = '0;
                n_ok_alive      = 1'b1;
                n_err_alive     = 1'b1;
                n_term          = '0;
                n_body_cnt      = '0;
            end
        endcase

        n_out.response_ok = n_ok_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hdr_cnt   <= '0;
            r_ok_alive  <= 1'b1;
            r_err_alive <= 1'b1;
            r_term      <= '0;
            r_body_cnt  <= '0;
            r_ok_flag   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_ok_alive  <= n_ok_alive;
                r_err_alive <= n_err_alive;
                r_term      <= n_term;
                r_body_cnt  <= n_body_cnt;
                r_ok_flag   <= n_ok_flag;
            end
            if (o_take) begin
                r_out_valid <= i_item.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/at_response_framer_top.sv
// at_response_framer_top: AT response framer, byte in, one event out per byte
// depends on atrf_pkg, atrf_stream_if, atrf_in_stage and atrf_core
`timescale 1ns / 1ps

// Each received byte gives exactly one result. A taken byte sits in the input register
// and passes through the event logic into the result register once the core takes it,
// which waits while a result is held and not taken. A new byte is taken every cycle as long
// as results are taken; the result register and input register together hold two
// bytes when the output stalls. The result word packs event_res, body_byte, body_index
// and response_ok from the most significant end. BODY_LIMIT sets the body
// byte count that raises an overflow; body_index carries the low 11 bits of
// the position.
module at_response_framer_top #(
    parameter int BODY_LIMIT = atrf_pkg::BODY_LIMIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    atrf_stream_if.sink   i_rx,
    atrf_stream_if.source o_res
);
    import atrf_pkg::*;

    t_item   w_item;
    logic    w_take;
    logic    w_out_valid;
    t_result w_result;

    atrf_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_rx_byte (i_rx.data[RX_BYTE_W-1:0]),
        .i_take    (w_take),
        .o_ready   (i_rx.ready),
        .o_item    (w_item)
    );

    atrf_core #(
        .BODY_LIMIT (BODY_LIMIT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .i_ready  (o_res.ready),
        .o_take   (w_take),
        .o_valid  (w_out_valid),
        .o_result (w_result)
    );

    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_result;

    // a held byte that the core takes shows up as a result next cycle
    a_take_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item.valid && w_take) |=> w_out_valid)
        else $error("taken byte produced no result");

    // header events fix the ok flag
    a_ok_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_result.event_res == EV_OK) |-> w_result.response_ok)
        else $error("ok header without ok flag");

    a_not_ok_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && (w_result.event_res == EV_ERR ||
                         w_result.event_res == EV_UNKNOWN)) |-> !w_result.response_ok)
        else $error("err or unknown header with ok flag set");

    // only body and complete events carry byte and index
    a_quiet_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_result.event_res != EV_BODY && w_result.event_res != EV_DONE)
        |-> (w_result.body_byte == '0 && w_result.body_index == '0))
        else $error("non-body event carries body data");

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for at_response_framer_top, byte requests in, one event out per byte
// depends on atrf_pkg, atrf_stream_if and the framer rtl; predicts each event in-bench and
// compares field by field under random source gaps and sink stalls
`timescale 1ns / 1ps

module tb_top;
    import atrf_pkg::*;

    localparam int          BODY_LIMIT_TB = BODY_LIMIT_DEF;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ITEMS  = 700;
    localparam logic [15:0] OK_TEXT       = "OK";
    localparam logic [23:0] ERR_TEXT      = "ERR";

    typedef enum logic [1:0] {
        FR_IDLE = 2'd0,
        FR_HEAD = 2'd1,
        FR_BODY = 2'd2
    } t_frame_phase;

    logic i_clk;
    logic i_rst_n;

    atrf_stream_if #(.W(RX_BYTE_W)) rx_if ();
    atrf_stream_if #(.W(RESULT_W))  res_if ();

    at_response_framer_top #(
        .BODY_LIMIT(BODY_LIMIT_TB)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_res   (res_if.source)
    );

    // framer state as predicted
    t_frame_phase fr_phase;
    logic [1:0]   fr_hdr_cnt;
    bit           fr_ok_alive;
    bit           fr_err_alive;
    logic [1:0]   fr_term;
    int unsigned  fr_body_cnt;
    bit           fr_ok_flag;

    t_result pending_events[$];
    int      fail_count        = 0;
    int      cycle_count       = 0;
    int      rx_sent           = 0;
    bit      src_gaps_on       = 1'b1;
    bit      sink_stalls_on    = 1'b1;
    int      sink_hold_request = 0;
    int      sink_hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void frame_go_idle();
        fr_phase     = FR_IDLE;
        fr_hdr_cnt   = 2'd0;
        fr_ok_alive  = 1'b1;
        fr_err_alive = 1'b1;
        fr_term      = 2'd0;
        fr_body_cnt  = 0;
    endfunction

    function automatic t_result frame_byte(input t_byte b);
        t_result     r;
        logic [1:0]  c;
        logic [1:0]  p;
        bit          ok_m;
        bit          err_m;
        bit          done;
        t_byte       want;
        int unsigned idx;
        r.event_res  = EV_IGNORED;
        r.body_byte  = '0;
        r.body_index = '0;
        done         = 1'b0;
        case (fr_phase)
            FR_HEAD: begin
                c     = fr_hdr_cnt;
                ok_m  = fr_ok_alive && c < 2 && b == OK_TEXT[15 - 8 * c[0] -: 8];
                err_m = fr_err_alive && c < 3 && b == ERR_TEXT[23 - 8 * (c < 3 ? c : 0) -: 8];
                if (ok_m && c == 2'd1) begin
                    r.event_res = EV_OK;
                    fr_ok_flag  = 1'b1;
                    frame_go_idle();
                    fr_phase    = FR_BODY;
                end else if (err_m && c == 2'd2) begin
                    r.event_res = EV_ERR;
                    fr_ok_flag  = 1'b0;
                    frame_go_idle();
                    fr_phase    = FR_BODY;
                end else if (!ok_m && !err_m) begin
                    r.event_res = EV_UNKNOWN;
                    fr_ok_flag  = 1'b0;
                    frame_go_idle();
                end else begin
                    r.event_res  = EV_HEAD;
                    fr_ok_alive  = ok_m;
                    fr_err_alive = err_m;
                    fr_hdr_cnt   = c + 2'd1;
                end
            end
            FR_BODY: begin
                p    = fr_term;
                want = p[0] ? CH_LF : CH_CR;
                idx  = fr_body_cnt;
                if (b == want) begin
                    if (p == 2'd3) done = 1'b1;
                    else p = p + 2'd1;
                end else begin
                    p = (b == CH_CR) ? 2'd1 : 2'd0;
                end
                if (done) begin
                    r.event_res  = EV_DONE;
                    r.body_byte  = b;
                    r.body_index = idx[BODY_INDEX_W-1:0];
                    frame_go_idle();
                end else begin
                    fr_body_cnt = idx + 1;
                    fr_term     = p;
                    if (fr_body_cnt >= BODY_LIMIT_TB) begin
                        r.event_res = EV_OVERFLOW;
                        frame_go_idle();
                    end else begin
                        r.event_res  = EV_BODY;
                        r.body_byte  = b;
                        r.body_index = idx[BODY_INDEX_W-1:0];
                    end
                end
            end
            default: begin
                frame_go_idle();
                if (b == SYNC_CHAR) begin
                    r.event_res = EV_HEAD;
                    fr_phase    = FR_HEAD;
                end
            end
        endcase
        r.response_ok = fr_ok_flag;
        return r;
    endfunction

    // one request on the byte channel, expectation queued on acceptance
    task automatic send_rx(input t_byte b);
        int gap;
        rx_if.valid <= 1'b1;
        rx_if.data  <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        pending_events.push_back(frame_byte(b));
        rx_sent++;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_rx(t_byte'(s[i]));
    endtask

    task automatic send_terminator();
        send_rx(CH_CR);
        send_rx(CH_LF);
        send_rx(CH_CR);
        send_rx(CH_LF);
    endtask

    function automatic t_byte pick_body_byte();
        case ($urandom_range(0, 9))
            0, 1:    return CH_CR;
            2:       return CH_LF;
            3:       return SYNC_CHAR;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byte pick_plain_byte();
        t_byte b;
        b = t_byte'($urandom_range(0, 255));
        return (b == CH_CR) ? CH_LF : b;
    endfunction

    // sink side with random stalls and an on-demand long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (sink_hold_request > 0) begin
            sink_hold_left    = sink_hold_request;
            sink_hold_request = 0;
            res_if.ready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left--;
            res_if.ready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
            sink_hold_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(10, 30);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = t_result'(res_if.data);
            if (pending_events.size() == 0) begin
                $error("unexpected result, event_res %0d", got.event_res);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                if (got.event_res !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                    fail_count++;
                end
                if (got.body_byte !== want.body_byte) begin
                    $error("body_byte: expected %0h, got %0h", want.body_byte, got.body_byte);
                    fail_count++;
                end
                if (got.body_index !== want.body_index) begin
                    $error("body_index: expected %0d, got %0d", want.body_index,
                           got.body_index);
                    fail_count++;
                end
                if (got.response_ok !== want.response_ok) begin
                    $error("response_ok: expected %0d, got %0d", want.response_ok,
                           got.response_ok);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_idle_bytes();
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(CH_CR);
        send_rx(CH_LF);
        send_text("OK");
    endtask

    task automatic test_ok_response();
        send_text("+OKab");
        send_terminator();
    endtask

    task automatic test_err_response();
        send_text("+ERR");
        send_rx(8'h80);
        send_terminator();
    endtask

    task automatic test_unknown_header();
        send_text("+OE");
        send_text("+ERX");
        send_text("++");
        send_text("+Z");
    endtask

    // broken terminators: cr restarting a partial match, stray lf
    task automatic test_terminator_restart();
        send_text("+OK");
        send_rx(CH_CR);
        send_rx(CH_LF);
        send_rx(CH_CR);
        send_rx(CH_CR);
        send_rx(CH_LF);
        send_rx(CH_LF);
        send_rx(CH_CR);
        send_rx(CH_CR);
        send_terminator();
    endtask

    // body runs to the limit without a terminator
    task automatic test_overflow();
        src_gaps_on = 1'b0;
        send_text("+OK");
        repeat (BODY_LIMIT_TB) send_rx(pick_plain_byte());
        send_text("+ERRx");
        send_terminator();
        src_gaps_on = 1'b1;
    endtask

    // sink holds off long while requests keep coming, input must stall
    task automatic test_backpressure();
        src_gaps_on       = 1'b0;
        sink_hold_request = 120;
        send_text("+OK");
        repeat (37) send_rx(pick_plain_byte());
        send_terminator();
        src_gaps_on = 1'b1;
    endtask

    task automatic send_random_response();
        int kind;
        int len;
        send_rx(SYNC_CHAR);
        kind = $urandom_range(0, 19);
        if (kind < 9) begin
            send_text("OK");
        end else if (kind < 18) begin
            send_text("ERR");
        end else begin
            if ($urandom_range(0, 1)) send_rx(8'h45);
            if ($urandom_range(0, 1)) send_rx(8'h52);
            send_rx(t_byte'($urandom_range(0, 255)));
            return;
        end
        len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 24) : $urandom_range(25, 120);
        repeat (len) send_rx(pick_body_byte());
        if ($urandom_range(0, 9) != 0) send_terminator();
    endtask

    task automatic test_random_traffic();
        int start;
        start = rx_sent;
        while (rx_sent - start < RANDOM_ITEMS) begin
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_rx($urandom_range(0, 3) == 0 ? SYNC_CHAR
                                                      : t_byte'($urandom_range(0, 255)));
                end
            end else begin
                send_random_response();
            end
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        rx_if.valid  <= 1'b0;
        rx_if.data   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        frame_go_idle();
        fr_ok_flag = 1'b0;

        test_idle_bytes();
        test_ok_response();
        test_err_response();
        test_unknown_header();
        test_terminator_restart();
        test_backpressure();
        test_overflow();
        test_random_traffic();

        rx_if.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/atrf_pkg.sv
rtl/atrf_stream_if.sv
rtl/atrf_in_stage.sv
rtl/atrf_core.sv
rtl/at_response_framer_top.sv
bench/tb_top.sv
